// ===== rtl/sfla_pkg.sv =====
// Package for the segment free-list allocator: defaults, codes and FSM state type.
package sfla_pkg;

  localparam int DEF_FREE_ENTRIES = 64;
  localparam int DEF_MAX_SEGMENTS = 6;
  localparam int DEF_ADDRESS_BITS = 16;

  localparam logic [15:0] POOL_RESET = 16'd4096;
  localparam int MIN_TABLE_CELLS = 13;
  localparam int CONTROL_CELLS   = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STS_GRANT    = 3'd0;
  localparam logic [2:0] STS_NO_BLOCK = 3'd1;
  localparam logic [2:0] STS_INSUFF   = 3'd2;
  localparam logic [2:0] STS_FREED    = 3'd3;
  localparam logic [2:0] STS_FULL     = 3'd4;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_P_CHK, ST_P_HEAD, ST_P_SCAN, ST_P_SH_RD, ST_P_SH_WR,
    ST_R_RD, ST_R_WR,
    ST_C_START, ST_C_FIRST, ST_C_NEXT, ST_C_FLUSH,
    ST_A_CHECK, ST_L_TEST, ST_L_EVAL, ST_L_SPLIT, ST_L_END, ST_B_LOOP,
    ST_F_DONE, ST_O_ONE, ST_O_GRANT
  } fsm_t;

endpackage

// ===== rtl/segment_free_list_allocator_top.sv =====
// Segment free-list allocator: free-extent table in one memory, walked by an FSM.
//
//  channel | signals                                   | dir | meaning
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid in_stall opcode request_cells    | in  | allocate / free request
//          | free_start free_size                      |     |
//  out     | out_valid out_stall status seg_index      | out | one result per segment
//          | seg_start seg_size last                   |     |
//  cfg     | cfg_valid cfg_ready cfg_data              | in  | pool_size write
//
//  One item at a time. A free scans the table, then shifts entries with a
//  read/write pair per moved entry through the memory. An allocate takes one
//  merge pass, then one shift pass per extent taken, per split leftover and per
//  grant put back, plus a test and an evaluation per skipped entry. The worst
//  case takes six grants (the default limit), then puts all of them back.
//  Reset (synchronous, rst high) and any pool_size write pass through an init
//  state that rewrites entry 0 before the next transaction is taken.
//  A waiting result sits in the output register; a stalled result holds the FSM.
module segment_free_list_allocator_top #(
  parameter int FREE_ENTRIES = sfla_pkg::DEF_FREE_ENTRIES,
  parameter int MAX_SEGMENTS = sfla_pkg::DEF_MAX_SEGMENTS,
  parameter int ADDRESS_BITS = sfla_pkg::DEF_ADDRESS_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [15:0] request_cells,
  input  logic [15:0] free_start,
  input  logic [15:0] free_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [2:0]  seg_index,
  output logic [15:0] seg_start,
  output logic [15:0] seg_size,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AB  = ADDRESS_BITS;
  localparam int IW  = $clog2(FREE_ENTRIES);          // memory address bits
  localparam int CW  = $clog2(FREE_ENTRIES + 1);      // entry counters
  localparam int NW  = $clog2(MAX_SEGMENTS + 1);      // grant counters
  localparam int GIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int XW  = ((AB > 16) ? AB : 16) + CW + 2; // need / got / total
  localparam logic [XW-1:0] OVERHEAD =
    XW'(sfla_pkg::CONTROL_CELLS + sfla_pkg::MIN_TABLE_CELLS);
  localparam logic [AB-1:0] MIN_LEN = AB'(sfla_pkg::MIN_TABLE_CELLS);

  // free-extent memory, one write and one registered read per cycle
  logic [AB-1:0] mem_s [FREE_ENTRIES];
  logic [AB-1:0] mem_l [FREE_ENTRIES];
  logic [IW-1:0] mra, mwa;
  logic          mwe;
  logic [AB-1:0] mws, mwl, rd_s, rd_l;

  // grants of the current allocation
  logic [AB-1:0] gs [MAX_SEGMENTS];
  logic [AB-1:0] gl [MAX_SEGMENTS];
  logic          gwe;
  logic [GIW-1:0] gwa;
  logic [AB-1:0] gws, gwl;

  sfla_pkg::fsm_t state, state_next, ret, ret_next;
  logic [15:0]   pool, pool_next;
  logic [CW-1:0] cnt, cnt_next, pos, pos_next, j, j_next, k, k_next;
  logic [CW-1:0] r, r_next, wp, wp_next, first, first_next, i, i_next;
  logic [AB-1:0] ps, ps_next, pl, pl_next, cur_s, cur_s_next, cur_l, cur_l_next;
  logic [AB-1:0] bs, bs_next, bl, bl_next, es, es_next, el, el_next, sv, sv_next;
  logic [XW-1:0] total, total_next, need, need_next, got, got_next, still;
  logic          found, found_next, place_ok, place_ok_next;
  logic [NW-1:0] n, n_next, e, e_next;
  logic [2:0]    res, res_next;
  logic [AB:0]   end_sum, len_sum;
  logic [XW-1:0] sel_s, sel_l;

  logic          ov_load, ov_last;
  logic [2:0]    ov_st, ov_idx;
  logic [15:0]   ov_s, ov_l;

  assign in_stall  = (state != sfla_pkg::ST_IDLE) || cfg_valid;
  assign cfg_ready = 1'b1;
  assign still     = need - got;
  assign end_sum   = {1'b0, cur_s} + {1'b0, cur_l};
  assign len_sum   = {1'b0, cur_l} + {1'b0, rd_l};
  assign sel_s     = XW'(gs[e[GIW-1:0]]);
  assign sel_l     = XW'(gl[e[GIW-1:0]]);

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem_s[mwa] <= mws;
      mem_l[mwa] <= mwl;
    end
    rd_s <= mem_s[mra];
    rd_l <= mem_l[mra];
    if (gwe) begin
      gs[gwa] <= gws;
      gl[gwa] <= gwl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sfla_pkg::ST_INIT;
      ret      <= sfla_pkg::ST_IDLE;
      pool     <= sfla_pkg::POOL_RESET;
      cnt      <= '0;
      found    <= 1'b0;
      place_ok <= 1'b0;
      n        <= '0;
      e        <= '0;
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      pool     <= pool_next;
      cnt      <= cnt_next;
      found    <= found_next;
      place_ok <= place_ok_next;
      n        <= n_next;
      e        <= e_next;
    end
    pos <= pos_next;  j <= j_next;  k <= k_next;  r <= r_next;
    wp <= wp_next;  first <= first_next;  i <= i_next;
    ps <= ps_next;  pl <= pl_next;  cur_s <= cur_s_next;  cur_l <= cur_l_next;
    bs <= bs_next;  bl <= bl_next;  es <= es_next;  el <= el_next;  sv <= sv_next;
    total <= total_next;  need <= need_next;  got <= got_next;  res <= res_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ov_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (ov_load) begin
      status    <= ov_st;
      seg_index <= ov_idx;
      seg_start <= ov_s;
      seg_size  <= ov_l;
      last      <= ov_last;
    end
  end

  always_comb begin
    state_next = state;  ret_next = ret;  pool_next = pool;  cnt_next = cnt;
    pos_next = pos;  j_next = j;  k_next = k;  r_next = r;  wp_next = wp;
    first_next = first;  i_next = i;  ps_next = ps;  pl_next = pl;
    cur_s_next = cur_s;  cur_l_next = cur_l;  bs_next = bs;  bl_next = bl;
    es_next = es;  el_next = el;  sv_next = sv;  total_next = total;
    need_next = need;  got_next = got;  found_next = found;
    place_ok_next = place_ok;  n_next = n;  e_next = e;  res_next = res;
    mra = '0;  mwe = 1'b0;  mwa = '0;  mws = '0;  mwl = '0;
    gwe = 1'b0;  gwa = '0;  gws = '0;  gwl = '0;
    ov_load = 1'b0;  ov_st = sfla_pkg::STS_GRANT;  ov_idx = '0;
    ov_s = '0;  ov_l = '0;  ov_last = 1'b1;

    case (state)
      sfla_pkg::ST_INIT: begin
        mwe = 1'b1;
        mwl = AB'(pool);
        cnt_next = CW'(1);
        state_next = sfla_pkg::ST_IDLE;
      end
      sfla_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (opcode == sfla_pkg::OP_FREE) begin
            ps_next = AB'(free_start);
            pl_next = AB'(free_size);
            ret_next = sfla_pkg::ST_F_DONE;
            state_next = sfla_pkg::ST_P_CHK;
          end else begin
            need_next = XW'(request_cells) + OVERHEAD;
            state_next = sfla_pkg::ST_C_START;
          end
        end
      end
      // ordered insert of (ps, pl)
      sfla_pkg::ST_P_CHK: begin
        k_next = cnt;
        if (cnt >= CW'(FREE_ENTRIES)) begin
          place_ok_next = 1'b0;
          state_next = ret;
        end else if (cnt == '0) begin
          pos_next = '0;
          state_next = sfla_pkg::ST_P_SH_RD;
        end else begin
          state_next = sfla_pkg::ST_P_HEAD;
        end
      end
      sfla_pkg::ST_P_HEAD: begin
        if (ps < rd_s) begin
          pos_next = '0;
          state_next = sfla_pkg::ST_P_SH_RD;
        end else if (cnt > CW'(1)) begin
          mra = IW'(1);
          j_next = CW'(1);
          state_next = sfla_pkg::ST_P_SCAN;
        end else begin
          pos_next = CW'(1);
          state_next = sfla_pkg::ST_P_SH_RD;
        end
      end
      sfla_pkg::ST_P_SCAN: begin
        if (rd_s < ps) begin
          j_next = j + 1'b1;
          if ((j + 1'b1) < cnt) begin
            mra = IW'(j + 1'b1);
          end else begin
            pos_next = j + 1'b1;
            state_next = sfla_pkg::ST_P_SH_RD;
          end
        end else begin
          pos_next = j;
          state_next = sfla_pkg::ST_P_SH_RD;
        end
      end
      sfla_pkg::ST_P_SH_RD: begin
        if (k > pos) begin
          mra = IW'(k - 1'b1);
          state_next = sfla_pkg::ST_P_SH_WR;
        end else begin
          mwe = 1'b1;
          mwa = pos[IW-1:0];
          mws = ps;
          mwl = pl;
          cnt_next = cnt + 1'b1;
          place_ok_next = 1'b1;
          state_next = ret;
        end
      end
      sfla_pkg::ST_P_SH_WR: begin
        mwe = 1'b1;
        mwa = k[IW-1:0];
        mws = rd_s;
        mwl = rd_l;
        k_next = k - 1'b1;
        state_next = sfla_pkg::ST_P_SH_RD;
      end
      // removal of entry k
      sfla_pkg::ST_R_RD: begin
        if ((k + 1'b1) < cnt) begin
          mra = IW'(k + 1'b1);
          state_next = sfla_pkg::ST_R_WR;
        end else begin
          cnt_next = cnt - 1'b1;
          state_next = ret;
        end
      end
      sfla_pkg::ST_R_WR: begin
        mwe = 1'b1;
        mwa = k[IW-1:0];
        mws = rd_s;
        mwl = rd_l;
        k_next = k + 1'b1;
        state_next = sfla_pkg::ST_R_RD;
      end
      // merge pass, compacting in place; totals taken from written entries
      sfla_pkg::ST_C_START: begin
        total_next = '0;
        found_next = 1'b0;
        wp_next = '0;
        r_next = CW'(1);
        state_next = (cnt == '0) ? sfla_pkg::ST_A_CHECK : sfla_pkg::ST_C_FIRST;
      end
      sfla_pkg::ST_C_FIRST: begin
        cur_s_next = rd_s;
        cur_l_next = rd_l;
        if (r < cnt) begin
          mra = r[IW-1:0];
          state_next = sfla_pkg::ST_C_NEXT;
        end else begin
          state_next = sfla_pkg::ST_C_FLUSH;
        end
      end
      sfla_pkg::ST_C_NEXT: begin
        if (end_sum == {1'b0, rd_s} && !len_sum[AB]) begin
          cur_l_next = len_sum[AB-1:0];
        end else begin
          mwe = 1'b1;
          mwa = wp[IW-1:0];
          mws = cur_s;
          mwl = cur_l;
          total_next = total + XW'(cur_l);
          if (!found && cur_l >= MIN_LEN) begin
            found_next = 1'b1;
            first_next = wp;
            bs_next = cur_s;
            bl_next = cur_l;
          end
          wp_next = wp + 1'b1;
          cur_s_next = rd_s;
          cur_l_next = rd_l;
        end
        r_next = r + 1'b1;
        if ((r + 1'b1) < cnt) begin
          mra = IW'(r + 1'b1);
        end else begin
          state_next = sfla_pkg::ST_C_FLUSH;
        end
      end
      sfla_pkg::ST_C_FLUSH: begin
        mwe = 1'b1;
        mwa = wp[IW-1:0];
        mws = cur_s;
        mwl = cur_l;
        total_next = total + XW'(cur_l);
        if (!found && cur_l >= MIN_LEN) begin
          found_next = 1'b1;
          first_next = wp;
          bs_next = cur_s;
          bl_next = cur_l;
        end
        cnt_next = wp + 1'b1;
        state_next = sfla_pkg::ST_A_CHECK;
      end
      sfla_pkg::ST_A_CHECK: begin
        i_next = '0;
        if (!found) begin
          res_next = sfla_pkg::STS_NO_BLOCK;
          state_next = sfla_pkg::ST_O_ONE;
        end else if (total < need) begin
          res_next = sfla_pkg::STS_INSUFF;
          state_next = sfla_pkg::ST_O_ONE;
        end else begin
          gwe = 1'b1;
          gws = bs;
          n_next = NW'(1);
          if (XW'(bl) > need) begin
            // split the first fit; the start wraps modulo the address space
            gwl = need[AB-1:0];
            mwe = 1'b1;
            mwa = first[IW-1:0];
            mws = bs + need[AB-1:0];
            mwl = bl - need[AB-1:0];
            got_next = need;
            state_next = sfla_pkg::ST_L_TEST;
          end else begin
            gwl = bl;
            got_next = XW'(bl);
            k_next = first;
            ret_next = sfla_pkg::ST_L_TEST;
            state_next = sfla_pkg::ST_R_RD;
          end
        end
      end
      // gather further extents at or above the first one's start
      sfla_pkg::ST_L_TEST: begin
        if (got < need && i < cnt && n < NW'(MAX_SEGMENTS)) begin
          mra = i[IW-1:0];
          state_next = sfla_pkg::ST_L_EVAL;
        end else begin
          state_next = sfla_pkg::ST_L_END;
        end
      end
      sfla_pkg::ST_L_EVAL: begin
        if (rd_s < bs) begin
          i_next = i + 1'b1;
          state_next = sfla_pkg::ST_L_TEST;
        end else begin
          k_next = i;
          gwe = 1'b1;
          gwa = n[GIW-1:0];
          gws = rd_s;
          n_next = n + 1'b1;
          if (XW'(rd_l) > still) begin
            gwl = still[AB-1:0];
            got_next = got + still;
            es_next = rd_s;
            el_next = rd_l;
            sv_next = still[AB-1:0];
            ret_next = sfla_pkg::ST_L_SPLIT;
          end else begin
            gwl = rd_l;
            got_next = got + XW'(rd_l);
            ret_next = sfla_pkg::ST_L_TEST;
          end
          state_next = sfla_pkg::ST_R_RD;
        end
      end
      sfla_pkg::ST_L_SPLIT: begin
        ps_next = es + sv;
        pl_next = el - sv;
        ret_next = sfla_pkg::ST_L_TEST;
        state_next = sfla_pkg::ST_P_CHK;
      end
      sfla_pkg::ST_L_END: begin
        e_next = '0;
        state_next = (got < need) ? sfla_pkg::ST_B_LOOP : sfla_pkg::ST_O_GRANT;
      end
      // short: put every grant back
      sfla_pkg::ST_B_LOOP: begin
        if (e < n) begin
          ps_next = sel_s[AB-1:0];
          pl_next = sel_l[AB-1:0];
          e_next = e + 1'b1;
          ret_next = sfla_pkg::ST_B_LOOP;
          state_next = sfla_pkg::ST_P_CHK;
        end else begin
          res_next = sfla_pkg::STS_INSUFF;
          state_next = sfla_pkg::ST_O_ONE;
        end
      end
      sfla_pkg::ST_F_DONE: begin
        res_next = place_ok ? sfla_pkg::STS_FREED : sfla_pkg::STS_FULL;
        state_next = sfla_pkg::ST_O_ONE;
      end
      sfla_pkg::ST_O_ONE: begin
        if (!out_valid || !out_stall) begin
          ov_load = 1'b1;
          ov_st = res;
          state_next = sfla_pkg::ST_IDLE;
        end
      end
      sfla_pkg::ST_O_GRANT: begin
        if (!out_valid || !out_stall) begin
          ov_load = 1'b1;
          ov_idx = 3'(e);
          ov_s = sel_s[15:0];
          ov_l = sel_l[15:0];
          ov_last = ((e + 1'b1) == n);
          e_next = e + 1'b1;
          if (ov_last) begin
            state_next = sfla_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sfla_pkg::ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      pool_next = cfg_data;
      state_next = sfla_pkg::ST_INIT;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(FREE_ENTRIES))
    else $error("extent count above table depth");
  a_grant_bound: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(MAX_SEGMENTS))
    else $error("grant count above segment limit");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ov_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != sfla_pkg::ST_IDLE))
    else $error("accepted transaction left no work");
`endif

endmodule

// ===== tb/tb_segment_free_list_allocator_top.sv =====
// Testbench for the segment free-list allocator: stimulus, predictor and scoreboard.
module tb_segment_free_list_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = sfla_pkg::DEF_FREE_ENTRIES;
  localparam int SEG_MAX = sfla_pkg::DEF_MAX_SEGMENTS;
  localparam longint unsigned ADDR_MASK = 64'hFFFF;
  localparam int CYCLE_LIMIT = 2000000;
  // quiet time before a pool write and at the end
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  seg_index;
    logic [15:0] seg_start;
    logic [15:0] seg_size;
    logic        last;
  } result_t;

  typedef struct {
    int unsigned start;
    int unsigned size;
  } extent_t;

  // Scoreboard: owns a copy of the free table and predicts every result.
  class alloc_scoreboard;
    int unsigned pool;
    int unsigned ext_start[TABLE_DEPTH];
    int unsigned ext_len[TABLE_DEPTH];
    int unsigned ext_cnt;
    int unsigned grant_st[SEG_MAX];
    int unsigned grant_len[SEG_MAX];
    result_t     expected_q[$];
    extent_t     held_q[$];
    int          errors;
    int          results_seen;
    int          grants_seen;

    function new();
      pool = sfla_pkg::POOL_RESET;
      errors = 0;
      results_seen = 0;
      grants_seen = 0;
      init_table();
    endfunction

    function void init_table();
      ext_start[0] = 0;
      ext_len[0] = pool;
      ext_cnt = 1;
      held_q.delete();
    endfunction

    function void set_pool(int unsigned v);
      pool = v & 16'hFFFF;
      init_table();
    endfunction

    function void remove_at(int unsigned pos);
      if (pos >= ext_cnt) return;
      for (int unsigned i = pos; i + 1 < ext_cnt; i++) begin
        ext_start[i] = ext_start[i + 1];
        ext_len[i] = ext_len[i + 1];
      end
      ext_cnt--;
    endfunction

    // ordered insert; no merging here
    function bit place(int unsigned s, int unsigned l);
      int unsigned pos;
      int unsigned i;
      if (ext_cnt >= TABLE_DEPTH) return 0;
      if (ext_cnt == 0 || s < ext_start[0]) begin
        pos = 0;
      end else begin
        i = 0;
        while (i + 1 < ext_cnt && ext_start[i + 1] < s) i++;
        pos = i + 1;
      end
      for (i = ext_cnt; i > pos; i--) begin
        ext_start[i] = ext_start[i - 1];
        ext_len[i] = ext_len[i - 1];
      end
      ext_start[pos] = s;
      ext_len[pos] = l;
      ext_cnt++;
      return 1;
    endfunction

    function void coalesce();
      int unsigned i;
      longint unsigned end_at;
      longint unsigned sum;
      i = 0;
      while (i + 1 < ext_cnt) begin
        end_at = longint'(ext_start[i]) + ext_len[i];
        sum = longint'(ext_len[i]) + ext_len[i + 1];
        if (end_at == ext_start[i + 1] && sum <= ADDR_MASK) begin
          ext_len[i] = 32'(sum);
          remove_at(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    function void push_one(logic [2:0] st);
      result_t r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void predict_alloc(int unsigned req);
      longint unsigned need;
      longint unsigned total;
      longint unsigned got;
      longint unsigned still;
      int first;
      int unsigned boundary;
      int unsigned n;
      int unsigned i;
      int unsigned s;
      int unsigned l;
      result_t r;
      extent_t h;
      need = longint'(sfla_pkg::CONTROL_CELLS + sfla_pkg::MIN_TABLE_CELLS) + req;
      total = 0;
      first = -1;
      coalesce();
      for (i = 0; i < ext_cnt; i++) begin
        total += ext_len[i];
        if (ext_len[i] >= sfla_pkg::MIN_TABLE_CELLS && first < 0) first = int'(i);
      end
      if (first < 0) begin
        push_one(sfla_pkg::STS_NO_BLOCK);
        return;
      end
      if (total < need) begin
        push_one(sfla_pkg::STS_INSUFF);
        return;
      end
      boundary = ext_start[first];
      grant_st[0] = boundary;
      if (ext_len[first] > need) begin
        grant_len[0] = 32'(need);
        ext_start[first] = 32'((boundary + need) & ADDR_MASK);
        ext_len[first] -= 32'(need);
      end else begin
        grant_len[0] = ext_len[first];
        remove_at(first);
      end
      got = grant_len[0];
      n = 1;
      i = 0;
      // gather further extents at or above the first one's start
      while (got < need && i < ext_cnt && n < SEG_MAX) begin
        s = ext_start[i];
        l = ext_len[i];
        still = need - got;
        if (s < boundary) begin
          i++;
          continue;
        end
        remove_at(i);
        grant_st[n] = s;
        if (l > still) begin
          grant_len[n] = 32'(still);
          got += still;
          void'(place(32'((s + still) & ADDR_MASK), l - 32'(still)));
        end else begin
          grant_len[n] = l;
          got += l;
        end
        n++;
      end
      if (got < need) begin
        for (i = 0; i < n; i++) void'(place(grant_st[i], grant_len[i]));
        push_one(sfla_pkg::STS_INSUFF);
        return;
      end
      for (i = 0; i < n; i++) begin
        r.status = sfla_pkg::STS_GRANT;
        r.seg_index = 3'(i);
        r.seg_start = 16'(grant_st[i]);
        r.seg_size = 16'(grant_len[i]);
        r.last = (i + 1 == n);
        expected_q.insert(expected_q.size(), r);
        h.start = grant_st[i];
        h.size = grant_len[i];
        held_q.insert(held_q.size(), h);
      end
    endfunction

    function void note_input(logic op, logic [15:0] req, logic [15:0] fs,
                             logic [15:0] fz);
      if (op == sfla_pkg::OP_ALLOC) predict_alloc(req);
      else push_one(place(fs, fz) ? sfla_pkg::STS_FREED : sfla_pkg::STS_FULL);
    endfunction

    task report(string what, result_t got, result_t exp);
      errors++;
      $display("MISMATCH %s: got st=%0d idx=%0d start=%0d size=%0d last=%0b, ",
               what, got.status, got.seg_index, got.seg_start, got.seg_size, got.last,
               "exp st=%0d idx=%0d start=%0d size=%0d last=%0b",
               exp.status, exp.seg_index, exp.seg_start, exp.seg_size, exp.last);
    endtask

    task check_result(result_t got);
      result_t exp;
      results_seen++;
      if (got.status == sfla_pkg::STS_GRANT) grants_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) report("status", got, exp);
      else if (got.seg_index !== exp.seg_index) report("seg_index", got, exp);
      else if (got.seg_start !== exp.seg_start) report("seg_start", got, exp);
      else if (got.seg_size !== exp.seg_size) report("seg_size", got, exp);
      else if (got.last !== exp.last) report("last", got, exp);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = sfla_pkg::OP_ALLOC;
  logic [15:0] request_cells = '0;
  logic [15:0] free_start = '0;
  logic [15:0] free_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  seg_index;
  logic [15:0] seg_start;
  logic [15:0] seg_size;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int send_idle_pct = 0;     // chance of the sender idling in a cycle
  int recv_stall_pct = 0;    // chance of stall in each cycle
  int items_sent = 0;
  int pool_writes = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  segment_free_list_allocator_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .request_cells(request_cells), .free_start(free_start), .free_size(free_size),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .seg_index(seg_index), .seg_start(seg_start), .seg_size(seg_size), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // receiver: stall pattern changes on the falling edge, results taken on the rising edge
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{status, seg_index, seg_start, seg_size, last});
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_q.size());
      $display("[segment_free_list_allocator_top] ERROR");
      $finish;
    end
  end

  // All driving tasks start and end right after a falling edge.
  task automatic send_item(input logic op, input logic [15:0] req,
                           input logic [15:0] fs, input logic [15:0] fz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    request_cells = req;
    free_start = fs;
    free_size = fz;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, req, fs, fz);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  // pool writes only with the block idle
  task automatic write_pool(input logic [15:0] v);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_pool(v);
    pool_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly well-formed traffic: small allocations and frees of granted segments.
  task automatic random_item();
    int pick;
    int k;
    extent_t e;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(sfla_pkg::OP_ALLOC, 16'($urandom()), '0, '0);
    end else if (pick < 48 || (pick < 88 && sb.held_q.size() == 0)) begin
      send_item(sfla_pkg::OP_ALLOC, 16'($urandom_range(0, 400)), 16'($urandom()),
                16'($urandom()));
    end else if (pick < 88) begin
      k = int'($urandom_range(sb.held_q.size() - 1));
      e = sb.held_q[k];
      sb.held_q.delete(k);
      send_item(sfla_pkg::OP_FREE, 16'($urandom()), 16'(e.start), 16'(e.size));
    end else begin
      send_item(sfla_pkg::OP_FREE, 16'($urandom()), 16'($urandom()),
                16'($urandom_range(1, 65535)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes on the reset pool
    send_item(sfla_pkg::OP_ALLOC, 16'd0, '0, '0);
    send_item(sfla_pkg::OP_ALLOC, 16'hFFFF, '0, '0);          // far beyond the pool
    send_item(sfla_pkg::OP_ALLOC, 16'd4096 - 16'd46, '0, '0); // takes the rest exactly
    send_item(sfla_pkg::OP_ALLOC, 16'd0, '0, '0);             // nothing left
    send_item(sfla_pkg::OP_FREE, '0, 16'd0, 16'd0);           // zero-length extent
    send_item(sfla_pkg::OP_FREE, '0, 16'd100, 16'd50);
    send_item(sfla_pkg::OP_FREE, '0, 16'd120, 16'd50);        // overlaps the previous one
    send_item(sfla_pkg::OP_FREE, '0, 16'd200, 16'd5);         // too small for a table
    send_item(sfla_pkg::OP_FREE, '0, 16'd205, 16'd20);        // meets the previous, merges
    send_item(sfla_pkg::OP_FREE, '0, 16'hFFF0, 16'hFFFF);     // start wraps when split
    send_item(sfla_pkg::OP_ALLOC, 16'd10, '0, '0);
    send_item(sfla_pkg::OP_ALLOC, 16'd200, '0, '0);
    send_item(sfla_pkg::OP_ALLOC, 16'd30, '0, '0);

    // pool below the minimum table size
    write_pool(16'd5);
    send_item(sfla_pkg::OP_ALLOC, 16'd0, '0, '0);
    send_item(sfla_pkg::OP_FREE, '0, 16'hFFFF, 16'd1);
    send_item(sfla_pkg::OP_ALLOC, 16'd1, '0, '0);

    // smallest legal pool, then the largest
    write_pool(16'd13);
    send_item(sfla_pkg::OP_ALLOC, 16'd0, '0, '0);
    write_pool(16'hFFFF);
    send_item(sfla_pkg::OP_FREE, '0, 16'hFFFF, 16'hFFFF);     // merge would overflow
    send_item(sfla_pkg::OP_ALLOC, 16'hFFFF - 16'd23, '0, '0);
    send_item(sfla_pkg::OP_ALLOC, 16'd100, '0, '0);

    // fragmented pool: a request spread over several segments
    write_pool(16'd40);
    for (int i = 0; i < 6; i++)
      send_item(sfla_pkg::OP_FREE, '0, 16'd1000 + 16'(i * 20), 16'd15);
    send_item(sfla_pkg::OP_ALLOC, 16'd90, '0, '0);
    send_item(sfla_pkg::OP_ALLOC, 16'd150, '0, '0);           // asks for more than is left free

    // fill the table, one free past full
    write_pool(16'd4096);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(sfla_pkg::OP_FREE, '0, 16'd5000 + 16'(i * 3), 16'd1);
    send_item(sfla_pkg::OP_ALLOC, 16'd8, '0, '0);

    write_pool(16'd4096);
    // random traffic under changing flow control
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < 22; i++) begin
        random_item();
        if (phase == 1 && i == 20) wait_drain();   // sender holds off until drained
      end
      if (phase == 1) write_pool(16'($urandom_range(13, 65535)));
      if (phase == 2) write_pool(16'd600);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d items, %0d results (%0d granted segments), %0d pool writes",
             items_sent, sb.results_seen, sb.grants_seen, pool_writes);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[segment_free_list_allocator_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("[segment_free_list_allocator_top] ERROR");
    end
    $finish;
  end
endmodule

// ===== segment_free_list_allocator_top.f =====
rtl/sfla_pkg.sv
rtl/segment_free_list_allocator_top.sv
tb/tb_segment_free_list_allocator_top.sv
